// File: hw/rtl/lpde_pkg.sv
// shared types and constants of the led pixel draw engine
// no dependencies; imported by the controller, the datapath and the top level
package lpde_pkg;

    // store geometry
    localparam int LPDE_PIXELS   = 16;
    localparam int LPDE_MAX_EMIT = 16;

    // hsv conversion constants
    localparam logic [8:0]  HUE_LIMIT   = 9'd360;
    localparam logic [5:0]  SECTOR_SPAN = 6'd60;
    localparam logic [14:0] RECIP_60    = 15'd17477;
    localparam int          RECIP_SHIFT = 20;
    localparam logic [7:0]  FULL_SCALE  = 8'd255;

    // operation codes
    typedef enum logic [2:0] {
        OP_CLEAR   = 3'd0,
        OP_SET_RGB = 3'd1,
        OP_ADD_HSV = 3'd2,
        OP_FADE    = 3'd3,
        OP_BAR     = 3'd4,
        OP_EMIT    = 3'd5
    } lpde_op_t;

    // one input transaction
    typedef struct packed {
        logic [2:0] operation;
        logic [3:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [8:0] hue;
        logic [7:0] saturation;
        logic [7:0] value;
        logic [7:0] bar_position;
        logic [3:0] bar_width;
        logic       wrap;
        logic [7:0] fade_amount;
    } lpde_item_t;

    // one result transaction
    typedef struct packed {
        logic [3:0] out_index;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic [7:0] out_blue;
        logic       last_pixel;
    } lpde_result_t;

    // stored pixel, green first
    typedef struct packed {
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] blue;
    } lpde_pixel_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic clear_all;
        logic write_rgb;
        logic hsv_a;
        logic hsv_b;
        logic hsv_c;
        logic hsv_d;
        logic bar_next;
        logic fade_rd;
        logic fade_wr;
        logic emit_rd;
        logic emit_out;
    } lpde_ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic is_bar;
        logic loop_done;
        logic bar_done;
    } lpde_sts_t;

endpackage

// File: hw/rtl/lpde_ctrl.sv
// command sequencer of the led pixel draw engine
// depends on lpde_pkg for the command, status and operation types
module lpde_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2:0]        operation,
    input  lpde_pkg::lpde_sts_t sts,
    output lpde_pkg::lpde_ctl_t ctl,
    output logic              busy
);
    import lpde_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HSV_A,
        S_HSV_B,
        S_HSV_C,
        S_HSV_D,
        S_FADE_RD,
        S_FADE_WR,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    case (operation)
                        OP_CLEAR:   ctl.clear_all = 1'b1;
                        OP_SET_RGB: ctl.write_rgb = 1'b1;
                        OP_ADD_HSV: state_next = S_HSV_A;
                        OP_BAR:     state_next = S_HSV_A;
                        OP_FADE:    state_next = S_FADE_RD;
                        OP_EMIT:    state_next = S_EMIT_RD;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_HSV_A:
            begin
                ctl.hsv_a  = 1'b1;
                state_next = S_HSV_B;
            end
            S_HSV_B:
            begin
                ctl.hsv_b  = 1'b1;
                state_next = S_HSV_C;
            end
            S_HSV_C:
            begin
                ctl.hsv_c  = 1'b1;
                state_next = S_HSV_D;
            end
            S_HSV_D:
            begin
                ctl.hsv_d = 1'b1;
                if (sts.is_bar && !sts.bar_done)
                begin
                    ctl.bar_next = 1'b1;
                    state_next   = S_HSV_A;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FADE_RD:
            begin
                if (sts.loop_done)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.fade_rd = 1'b1;
                    state_next  = S_FADE_WR;
                end
            end
            S_FADE_WR:
            begin
                ctl.fade_wr = 1'b1;
                state_next  = S_FADE_RD;
            end
            S_EMIT_RD:
            begin
                if (sts.loop_done)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.emit_rd = 1'b1;
                    state_next  = S_EMIT_OUT;
                end
            end
            S_EMIT_OUT:
            begin
                ctl.emit_out = 1'b1;
                state_next   = S_EMIT_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

// File: hw/rtl/lpde_datapath.sv
// frame store, colour pipeline and pixel loop of the led pixel draw engine
// depends on lpde_pkg; driven by lpde_ctrl through lpde_ctl_t
module lpde_datapath #(
    parameter int PIXELS = lpde_pkg::LPDE_PIXELS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lpde_pkg::lpde_ctl_t  ctl,
    output lpde_pkg::lpde_sts_t  sts,
    input  lpde_pkg::lpde_item_t command,
    input  logic [2:0]           brightness_shift,
    input  logic [4:0]           active_pixels,
    output logic                 result_strobe,
    output lpde_pkg::lpde_result_t result
);
    import lpde_pkg::*;

    localparam int IDX_W   = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int LOOP_W  = (IDX_W > 5) ? IDX_W : 5;
    localparam int CNT_MAX = (PIXELS < LPDE_MAX_EMIT) ? PIXELS : LPDE_MAX_EMIT;

    // frame store and its valid bits
    lpde_pixel_t        store_mem [PIXELS];
    logic [PIXELS-1:0]  valid_reg;
    lpde_pixel_t        rd_data_reg;
    logic               rd_valid_reg;

    // captured transaction and loop counters
    lpde_item_t         cmd_reg;
    logic [LOOP_W-1:0]  loop_reg;
    logic [LOOP_W-1:0]  loop_next;
    logic [3:0]         step_reg;

    // colour pipeline
    logic [7:0]         val_reg;
    logic [7:0]         base_reg;
    logic [2:0]         sector_reg;
    logic [5:0]         part_reg;
    logic               black_reg;
    logic               grey_reg;
    logic [13:0]        up_prod_reg;
    logic [13:0]        dn_prod_reg;
    logic [7:0]         up_reg;
    logic [7:0]         dn_reg;

    // outputs
    lpde_result_t       result_reg;
    logic               strobe_reg;

    // effective count
    logic [4:0]         cnt;
    logic [LOOP_W:0]    loop_inc;
    logic               loop_in_range;
    logic               loop_wraps;

    assign cnt = (active_pixels > 5'(CNT_MAX)) ? 5'(CNT_MAX) : active_pixels;
    assign loop_inc      = (LOOP_W+1)'(loop_reg) + (LOOP_W+1)'(1);
    assign loop_in_range = (loop_reg < LOOP_W'(cnt));
    assign loop_wraps    = (loop_inc == (LOOP_W+1)'(cnt));

    // status toward the controller
    assign sts.is_bar    = (cmd_reg.operation == OP_BAR);
    assign sts.loop_done = !loop_in_range;
    assign sts.bar_done  = (step_reg == cmd_reg.bar_width) || (!cmd_reg.wrap && loop_wraps);

    // stored pixel as read, invalid entries read as black
    lpde_pixel_t cur_pix;
    assign cur_pix = rd_valid_reg ? rd_data_reg : '0;

    // colour inputs for the first stage
    logic [7:0] hsv_val;
    logic [7:0] hsv_sat;
    logic [3:0] frac;
    logic [7:0] frac_scaled;
    logic [15:0] base_prod;
    logic [2:0] sector;
    logic [8:0] part_full;

    assign frac        = cmd_reg.bar_position[3:0];
    assign frac_scaled = {frac, 4'b0000};

    always_comb
    begin
        if (sts.is_bar)
        begin
            hsv_sat = FULL_SCALE;
            if (step_reg == 4'd0)
            begin
                hsv_val = FULL_SCALE - frac_scaled;
            end
            else if (step_reg == cmd_reg.bar_width)
            begin
                hsv_val = frac_scaled;
            end
            else
            begin
                hsv_val = FULL_SCALE;
            end
        end
        else
        begin
            hsv_sat = cmd_reg.saturation;
            hsv_val = cmd_reg.value;
        end
    end

    assign base_prod = 16'(FULL_SCALE - hsv_sat) * 16'(hsv_val);

    // hue sector and position inside it
    always_comb
    begin
        if (cmd_reg.hue < 9'd60)
        begin
            sector    = 3'd0;
            part_full = cmd_reg.hue;
        end
        else if (cmd_reg.hue < 9'd120)
        begin
            sector    = 3'd1;
            part_full = cmd_reg.hue - 9'd60;
        end
        else if (cmd_reg.hue < 9'd180)
        begin
            sector    = 3'd2;
            part_full = cmd_reg.hue - 9'd120;
        end
        else if (cmd_reg.hue < 9'd240)
        begin
            sector    = 3'd3;
            part_full = cmd_reg.hue - 9'd180;
        end
        else if (cmd_reg.hue < 9'd300)
        begin
            sector    = 3'd4;
            part_full = cmd_reg.hue - 9'd240;
        end
        else
        begin
            sector    = 3'd5;
            part_full = cmd_reg.hue - 9'd300;
        end
    end

    // second stage operands
    logic [7:0]  span;
    logic [5:0]  part_rev;
    assign span     = val_reg - base_reg;
    assign part_rev = SECTOR_SPAN - part_reg;

    // third stage: divide by sixty through the reciprocal
    logic [28:0] up_quot;
    logic [28:0] dn_quot;
    assign up_quot = 29'(up_prod_reg) * 29'(RECIP_60);
    assign dn_quot = 29'(dn_prod_reg) * 29'(RECIP_60);

    // fourth stage: channel select, saturating add and shift
    logic [7:0]  hsv_r;
    logic [7:0]  hsv_g;
    logic [7:0]  hsv_b;
    lpde_pixel_t hsv_pix;

    always_comb
    begin
        hsv_r = '0;
        hsv_g = '0;
        hsv_b = '0;
        if (black_reg)
        begin
            hsv_r = '0;
        end
        else if (grey_reg)
        begin
            hsv_r = val_reg;
            hsv_g = val_reg;
            hsv_b = val_reg;
        end
        else
        begin
            case (sector_reg)
                3'd0:
                begin
                    hsv_r = val_reg;  hsv_g = up_reg;   hsv_b = base_reg;
                end
                3'd1:
                begin
                    hsv_r = dn_reg;   hsv_g = val_reg;  hsv_b = base_reg;
                end
                3'd2:
                begin
                    hsv_r = base_reg; hsv_g = val_reg;  hsv_b = up_reg;
                end
                3'd3:
                begin
                    hsv_r = base_reg; hsv_g = dn_reg;   hsv_b = val_reg;
                end
                3'd4:
                begin
                    hsv_r = up_reg;   hsv_g = base_reg; hsv_b = val_reg;
                end
                default:
                begin
                    hsv_r = val_reg;  hsv_g = base_reg; hsv_b = dn_reg;
                end
            endcase
        end
    end

    function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[8] ? 8'hFF : sum[7:0];
    endfunction

    function automatic logic [7:0] sat_sub(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : 8'd0;
    endfunction

    assign hsv_pix.green = sat_add(cur_pix.green, hsv_g) >> brightness_shift;
    assign hsv_pix.red   = sat_add(cur_pix.red, hsv_r) >> brightness_shift;
    assign hsv_pix.blue  = sat_add(cur_pix.blue, hsv_b) >> brightness_shift;

    // fade of the pixel just read
    lpde_pixel_t fade_pix;
    assign fade_pix.green = sat_sub(cur_pix.green, cmd_reg.fade_amount);
    assign fade_pix.red   = sat_sub(cur_pix.red, cmd_reg.fade_amount);
    assign fade_pix.blue  = sat_sub(cur_pix.blue, cmd_reg.fade_amount);

    // direct write from the incoming transaction
    lpde_pixel_t       set_pix;
    logic [LOOP_W-1:0] set_idx;
    logic              set_in_range;
    assign set_pix.green = command.green >> brightness_shift;
    assign set_pix.red   = command.red >> brightness_shift;
    assign set_pix.blue  = command.blue >> brightness_shift;
    assign set_idx       = LOOP_W'(command.pixel_index);
    assign set_in_range  = ({1'b0, command.pixel_index} < cnt);

    // store write port
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    lpde_pixel_t       wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = loop_reg[IDX_W-1:0];
        wr_data = hsv_pix;
        if (ctl.write_rgb)
        begin
            wr_en   = set_in_range;
            wr_addr = set_idx[IDX_W-1:0];
            wr_data = set_pix;
        end
        else if (ctl.hsv_d)
        begin
            wr_en = loop_in_range;
        end
        else if (ctl.fade_wr)
        begin
            wr_en   = 1'b1;
            wr_data = fade_pix;
        end
    end

    assign rd_en   = ctl.hsv_a || ctl.fade_rd || ctl.emit_rd;
    assign rd_addr = loop_reg[IDX_W-1:0];

    // frame store memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // valid bits and registered read of them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear_all)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // loop counter next value
    always_comb
    begin
        loop_next = loop_reg;
        if (ctl.load)
        begin
            if (command.operation == OP_BAR)
            begin
                loop_next = LOOP_W'(command.bar_position[7:4]);
            end
            else if (command.operation == OP_ADD_HSV)
            begin
                loop_next = LOOP_W'(command.pixel_index);
            end
            else
            begin
                loop_next = '0;
            end
        end
        else if (ctl.bar_next)
        begin
            loop_next = loop_wraps ? '0 : loop_inc[LOOP_W-1:0];
        end
        else if (ctl.fade_wr || ctl.emit_out)
        begin
            loop_next = loop_inc[LOOP_W-1:0];
        end
    end

    // transaction capture, counters and colour pipeline
    always_ff @(posedge clk)
    begin
        loop_reg <= loop_next;
        if (ctl.load)
        begin
            cmd_reg  <= command;
            step_reg <= '0;
        end
        else if (ctl.bar_next)
        begin
            step_reg <= step_reg + 4'd1;
        end
        if (ctl.hsv_a)
        begin
            val_reg    <= hsv_val;
            base_reg   <= base_prod[15:8];
            sector_reg <= sector;
            part_reg   <= part_full[5:0];
            black_reg  <= (cmd_reg.hue >= HUE_LIMIT);
            grey_reg   <= (hsv_sat == 8'd0);
        end
        if (ctl.hsv_b)
        begin
            up_prod_reg <= 14'(span) * 14'(part_reg);
            dn_prod_reg <= 14'(span) * 14'(part_rev);
        end
        if (ctl.hsv_c)
        begin
            up_reg <= up_quot[RECIP_SHIFT+7:RECIP_SHIFT] + base_reg;
            dn_reg <= dn_quot[RECIP_SHIFT+7:RECIP_SHIFT] + base_reg;
        end
        if (ctl.emit_out)
        begin
            result_reg.out_index  <= loop_reg[3:0];
            result_reg.out_green  <= cur_pix.green;
            result_reg.out_red    <= cur_pix.red;
            result_reg.out_blue   <= cur_pix.blue;
            result_reg.last_pixel <= loop_wraps;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= ctl.emit_out;
        end
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule

// File: hw/rtl/led_pixel_draw_engine.sv
// top level of the led pixel draw engine: configuration registers and wiring
// depends on lpde_pkg, lpde_ctrl and lpde_datapath
//
// A command is taken when start is high and busy is low; busy stays high until
// the command has finished. Clear and set_rgb leave busy low. Add_hsv takes the
// command and then runs the colour pipeline steps in order: base product, ramp
// products, divide by sixty, add and write. A bar runs each drawn pixel through
// the same pipeline, one pixel after the other. Fade reads and then writes back
// each active pixel in turn. Emit gives one result per active pixel, in pixel
// order with last_pixel on the final one. Each result is shown on result for
// one cycle with result_strobe high; the receiver cannot stall it, so it must
// take every result in that cycle. Registers sit at byte addresses 0
// (brightness_shift) and 4 (active_pixels); write them only while busy is low.
module led_pixel_draw_engine #(
    parameter int PIXELS = lpde_pkg::LPDE_PIXELS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  lpde_pkg::lpde_item_t   command,
    output logic                   result_strobe,
    output lpde_pkg::lpde_result_t result,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import lpde_pkg::*;

    localparam logic REG_BRIGHTNESS = 1'b0;
    localparam logic REG_ACTIVE     = 1'b1;

    logic [2:0] brightness_shift_reg;
    logic [4:0] active_pixels_reg;
    logic       cfg_write;
    lpde_ctl_t  ctl;
    lpde_sts_t  sts;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_shift_reg <= 3'd0;
            active_pixels_reg    <= 5'd16;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_BRIGHTNESS: brightness_shift_reg <= pwdata[2:0];
                REG_ACTIVE:     active_pixels_reg    <= pwdata[4:0];
                default:        brightness_shift_reg <= brightness_shift_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (paddr[2])
            REG_BRIGHTNESS: prdata = {29'd0, brightness_shift_reg};
            REG_ACTIVE:     prdata = {27'd0, active_pixels_reg};
            default:        prdata = '0;
        endcase
    end

    // command sequencer
    lpde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (command.operation),
        .sts       (sts),
        .ctl       (ctl),
        .busy      (busy)
    );

    // store and colour datapath
    lpde_datapath #(
        .PIXELS (PIXELS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .sts              (sts),
        .command          (command),
        .brightness_shift (brightness_shift_reg),
        .active_pixels    (active_pixels_reg),
        .result_strobe    (result_strobe),
        .result           (result)
    );

endmodule

// File: verif/led_pixel_draw_engine_tb.sv
// testbench for the led pixel draw engine: commands, register writes and emitted pixels
// depends on lpde_pkg and led_pixel_draw_engine; a scoreboard class predicts the frame store
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lpde_pkg::*;

    // register addresses and the codes the engine must ignore
    localparam logic [2:0] REG_SHIFT_ADDR  = 3'd0;
    localparam logic [2:0] REG_ACTIVE_ADDR = 3'd4;
    localparam logic [2:0] OP_SPARE_LOW    = 3'd6;
    localparam logic [2:0] OP_SPARE_HIGH   = 3'd7;

    // settle time sized for a bar over all sixteen pixels
    localparam int BAR_DRAIN    = 80;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_LIMIT = 10;
    localparam int PHASES       = 8;

    // frame store predictor and emitted pixel checker
    class pixel_scoreboard;
        lpde_pixel_t  frame [LPDE_PIXELS];
        logic [2:0]   shift;
        logic [4:0]   active;
        lpde_result_t pending [$];
        int           commands;
        int           checked;
        int           failures;

        function new();
            foreach (frame[k]) frame[k] = '0;
            shift    = '0;
            active   = 5'd16;
            commands = 0;
            checked  = 0;
            failures = 0;
        endfunction

        function int lit_count();
            int n;
            n = int'(active);
            if (n > LPDE_PIXELS) n = LPDE_PIXELS;
            if (n > LPDE_MAX_EMIT) n = LPDE_MAX_EMIT;
            return n;
        endfunction

        function logic [7:0] saturate(int sum);
            return (sum > int'(FULL_SCALE)) ? FULL_SCALE : 8'(sum);
        endfunction

        // hsv to rgb in six sectors, added onto the pixel and then shifted
        function void add_colour(int idx, int hue, int sat, int val);
            int sector;
            int base;
            int span;
            int part;
            int up;
            int down;
            int r;
            int g;
            int b;
            sector = int'(SECTOR_SPAN);
            r = 0;
            g = 0;
            b = 0;
            if (idx >= lit_count()) return;
            if (hue < int'(HUE_LIMIT))
            begin
                if (sat == 0)
                begin
                    r = val;
                    g = val;
                    b = val;
                end
                else
                begin
                    base = ((int'(FULL_SCALE) - sat) * val) >> 8;
                    span = val - base;
                    part = hue % sector;
                    up   = span * part / sector + base;
                    down = span * (sector - part) / sector + base;
                    case (hue / sector)
                        0:       begin r = val;  g = up;   b = base; end
                        1:       begin r = down; g = val;  b = base; end
                        2:       begin r = base; g = val;  b = up;   end
                        3:       begin r = base; g = down; b = val;  end
                        4:       begin r = up;   g = base; b = val;  end
                        default: begin r = val;  g = base; b = down; end
                    endcase
                end
            end
            frame[idx].green = saturate(int'(frame[idx].green) + g) >> shift;
            frame[idx].red   = saturate(int'(frame[idx].red) + r) >> shift;
            frame[idx].blue  = saturate(int'(frame[idx].blue) + b) >> shift;
        endfunction

        // apply one accepted command transaction to the predicted store
        function void note_command(lpde_item_t c);
            int           lit;
            int           pos;
            int           first;
            int           bright;
            lpde_result_t r;
            lit = lit_count();
            commands++;
            case (c.operation)
                OP_CLEAR:
                begin
                    foreach (frame[k]) frame[k] = '0;
                end
                OP_SET_RGB:
                begin
                    if (int'(c.pixel_index) < lit)
                    begin
                        frame[c.pixel_index].green = c.green >> shift;
                        frame[c.pixel_index].red   = c.red >> shift;
                        frame[c.pixel_index].blue  = c.blue >> shift;
                    end
                end
                OP_ADD_HSV:
                begin
                    add_colour(int'(c.pixel_index), int'(c.hue), int'(c.saturation),
                               int'(c.value));
                end
                OP_FADE:
                begin
                    for (int k = 0; k < lit; k++)
                    begin
                        frame[k].green = (frame[k].green > c.fade_amount) ?
                                         frame[k].green - c.fade_amount : 8'd0;
                        frame[k].red   = (frame[k].red > c.fade_amount) ?
                                         frame[k].red - c.fade_amount : 8'd0;
                        frame[k].blue  = (frame[k].blue > c.fade_amount) ?
                                         frame[k].blue - c.fade_amount : 8'd0;
                    end
                end
                OP_BAR:
                begin
                    // soft edges from the fractional part of the position
                    pos   = int'(c.bar_position[7:4]);
                    first = int'(FULL_SCALE) - 16 * int'(c.bar_position[3:0]);
                    for (int n = 0; n <= int'(c.bar_width); n++)
                    begin
                        if (n == 0) bright = first;
                        else if (n == int'(c.bar_width)) bright = int'(FULL_SCALE) - first;
                        else bright = int'(FULL_SCALE);
                        add_colour(pos, int'(c.hue), int'(FULL_SCALE), bright);
                        pos++;
                        if (pos == lit)
                        begin
                            if (c.wrap) pos = 0;
                            else break;
                        end
                    end
                end
                OP_EMIT:
                begin
                    for (int k = 0; k < lit; k++)
                    begin
                        r.out_index  = 4'(k);
                        r.out_green  = frame[k].green;
                        r.out_red    = frame[k].red;
                        r.out_blue   = frame[k].blue;
                        r.last_pixel = (k + 1 == lit);
                        pending.push_back(r);
                    end
                end
                default: ;
            endcase
        endfunction

        function void flag(string what, lpde_result_t want, lpde_result_t got);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("%s: expected %0d %h %h %h %b, got %0d %h %h %h %b",
                         what, want.out_index, want.out_green, want.out_red, want.out_blue,
                         want.last_pixel, got.out_index, got.out_green, got.out_red,
                         got.out_blue, got.last_pixel);
        endfunction

        // compare one emitted pixel with the oldest prediction
        function void check_result(lpde_result_t got);
            lpde_result_t want;
            if (pending.size() == 0)
            begin
                flag("pixel with nothing pending", '0, got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.out_index !== want.out_index || got.out_green !== want.out_green ||
                got.out_red !== want.out_red || got.out_blue !== want.out_blue ||
                got.last_pixel !== want.last_pixel)
                flag("pixel mismatch", want, got);
        endfunction
    endclass

    logic         clk;
    logic         rst_n   = 1'b0;
    logic         start   = 1'b0;
    logic         busy;
    lpde_item_t   command = '0;
    logic         result_strobe;
    lpde_result_t result;
    logic         psel    = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite  = 1'b0;
    logic [2:0]   paddr   = '0;
    logic [31:0]  pwdata  = '0;
    logic [31:0]  prdata;
    logic         pready;

    pixel_scoreboard tracker;
    int              cycle_count = 0;
    int              settings_used = 0;

    led_pixel_draw_engine u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .result_strobe (result_strobe),
        .result        (result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // every strobed pixel is checked at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
            tracker.check_result(result);
    end

    // fill every field at random so unused fields are exercised too
    function automatic lpde_item_t random_fields();
        lpde_item_t c;
        c.operation    = 3'($urandom);
        c.pixel_index  = 4'($urandom);
        c.red          = 8'($urandom);
        c.green        = 8'($urandom);
        c.blue         = 8'($urandom);
        c.hue          = 9'($urandom);
        c.saturation   = 8'($urandom);
        c.value        = 8'($urandom);
        c.bar_position = 8'($urandom);
        c.bar_width    = 4'($urandom);
        c.wrap         = 1'($urandom);
        c.fade_amount  = 8'($urandom);
        return c;
    endfunction

    // mostly drawing and emitting, with rare clears and unused codes
    function automatic lpde_item_t random_command();
        lpde_item_t c;
        int         pick;
        c    = random_fields();
        pick = $urandom_range(0, 99);
        if (pick < 4) c.operation = OP_CLEAR;
        else if (pick < 24) c.operation = OP_SET_RGB;
        else if (pick < 49) c.operation = OP_ADD_HSV;
        else if (pick < 61) c.operation = OP_FADE;
        else if (pick < 79) c.operation = OP_BAR;
        else if (pick < 97) c.operation = OP_EMIT;
        else c.operation = pick[0] ? OP_SPARE_LOW : OP_SPARE_HIGH;
        if ($urandom_range(0, 99) < 85) c.hue = 9'($urandom_range(0, 359));
        if ($urandom_range(0, 9) == 0) c.saturation = '0;
        if ($urandom_range(0, 9) < 7) c.fade_amount = 8'($urandom_range(0, 40));
        return c;
    endfunction

    // one command transaction; start stays high across back-to-back commands
    task automatic send_command(input lpde_item_t c, input bit burst);
        int gap;
        gap = (burst || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        command <= c;
        do @(posedge clk); while (busy);
        tracker.note_command(c);
    endtask

    task automatic send_rgb(input int idx, input int r, input int g, input int b);
        lpde_item_t c;
        c             = random_fields();
        c.operation   = OP_SET_RGB;
        c.pixel_index = 4'(idx);
        c.red         = 8'(r);
        c.green       = 8'(g);
        c.blue        = 8'(b);
        send_command(c, 1'b0);
    endtask

    task automatic send_hsv(input int idx, input int hue, input int sat, input int val);
        lpde_item_t c;
        c             = random_fields();
        c.operation   = OP_ADD_HSV;
        c.pixel_index = 4'(idx);
        c.hue         = 9'(hue);
        c.saturation  = 8'(sat);
        c.value       = 8'(val);
        send_command(c, 1'b0);
    endtask

    task automatic send_bar(input int pos, input int width, input int hue, input bit wrap);
        lpde_item_t c;
        c              = random_fields();
        c.operation    = OP_BAR;
        c.bar_position = 8'(pos);
        c.bar_width    = 4'(width);
        c.hue          = 9'(hue);
        c.wrap         = wrap;
        send_command(c, 1'b0);
    endtask

    task automatic send_plain(input logic [2:0] op, input int fade);
        lpde_item_t c;
        c             = random_fields();
        c.operation   = op;
        c.fade_amount = 8'(fade);
        send_command(c, 1'b0);
    endtask

    // hold commands off until every pixel is in and the engine is quiet
    task automatic settle_engine();
        start <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge clk);
        repeat (BAR_DRAIN) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // write both registers back to back over the configuration port
    task automatic apply_settings(input int shift, input int active);
        for (int k = 0; k < 2; k++)
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= (k == 0) ? REG_SHIFT_ADDR : REG_ACTIVE_ADDR;
            pwdata  <= (k == 0) ? 32'(shift) : 32'(active);
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            if (k == 0) tracker.shift = 3'(shift);
            else tracker.active = 5'(active);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    // random commands under one register setting, closed by an emit
    task automatic run_phase(input int shift, input int active, input int items);
        lpde_item_t c;
        int         counted;
        bit         burst;
        apply_settings(shift, active);
        burst   = ($urandom_range(0, 2) == 0);
        counted = 0;
        while (counted < items - 1)
        begin
            c = random_command();
            if (c.operation != OP_SPARE_LOW && c.operation != OP_SPARE_HIGH) counted++;
            send_command(c, burst);
        end
        send_plain(OP_EMIT, 0);
        settle_engine();
    endtask

    initial
    begin
        int shift_set  [PHASES] = '{7, 0, 3, 0, 1, 0, 2, 0};
        int active_set [PHASES] = '{16, 1, 5, 31, 0, 16, 9, 16};
        int length_set [PHASES] = '{10, 8, 10, 10, 6, 14, 12, 15};
        int wait_cycles;
        tracker = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: channel extremes, every hsv sector, black hues, grey, bar edges
        send_rgb(0, 255, 255, 255);
        send_rgb(15, 8'hAA, 8'h55, 8'h01);
        send_rgb(7, 0, 128, 255);
        send_plain(OP_EMIT, 0);
        send_hsv(0, 0, 255, 255);
        send_hsv(1, 359, 255, 255);
        send_hsv(2, 360, 255, 255);
        send_hsv(3, 511, 0, 255);
        send_hsv(4, 100, 0, 200);
        send_hsv(5, 60, 128, 77);
        send_hsv(6, 150, 200, 255);
        send_hsv(8, 200, 1, 255);
        send_hsv(9, 250, 255, 128);
        send_hsv(10, 310, 90, 255);
        send_plain(OP_EMIT, 0);
        send_plain(OP_FADE, 0);
        send_plain(OP_FADE, 37);
        send_bar(0, 0, 0, 1'b0);
        send_bar(255, 15, 120, 1'b1);
        send_bar(8'h7A, 15, 240, 1'b0);
        send_plain(OP_SPARE_LOW, 0);
        send_plain(OP_SPARE_HIGH, 0);
        send_plain(OP_EMIT, 0);
        send_plain(OP_FADE, 255);
        send_plain(OP_EMIT, 0);
        settle_engine();

        // register sweep including no active pixel and a count above the store
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
                run_phase($urandom_range(0, 7), $urandom_range(1, 16), length_set[p]);
            else
                run_phase(shift_set[p], active_set[p], length_set[p]);
        end

        wait_cycles = 0;
        while (tracker.pending.size() != 0 && wait_cycles < 2000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (tracker.pending.size() != 0)
            tracker.flag("pixel never emitted", tracker.pending[0], '0);

        $display("ran %0d commands over %0d register settings, %0d emitted pixels checked",
                 tracker.commands, settings_used, tracker.checked);
        $display("%0d failures in total", tracker.failures);
        if (tracker.failures == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
